// File: sv/pip_pkg.sv
// Shared types and codes for the point-in-polygon tester.
package pip_pkg;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_TEST  = 2'd2;

	localparam logic signed [15:0] COORD_MAX = 16'sh7fff;
	localparam logic signed [15:0] COORD_MIN = 16'sh8000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BOX,
		ST_READ,
		ST_DRAIN,
		ST_RESULT
	} pip_state_t;

	// control from the sequencer to the edge unit
	typedef struct packed {
		logic start;  // new query: clear the crossing parity
		logic vld;    // a vertex arrives from the store
		logic first;  // it is the closing vertex (last one), only loaded as previous
	} pip_vtx_ctl_t;

endpackage

// File: sv/pip_ram.sv
// Generic single-port-write, registered-read RAM.
module pip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/pip_edge.sv
// Pipelined edge unit: half-open span test, cross-multiplied compare, parity toggle.
module pip_edge import pip_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  pip_vtx_ctl_t        ctl,
	input  logic signed [15:0]  vtx_x,
	input  logic signed [15:0]  vtx_y,
	input  logic signed [15:0]  qx,
	input  logic signed [15:0]  qy,
	output logic                busy,
	output logic                in_poly
);

	logic signed [15:0] prev_x_q, prev_y_q;
	logic               span_w;
	logic signed [16:0] dy_w, ax_w, bx_w, by_w;

	logic               v_s1;
	logic signed [16:0] dy_s1, ax_s1, bx_s1, by_s1;

	logic               v_s2;
	logic               dpos_s2;
	logic signed [33:0] lhs_s2, rhs_s2;

	logic               cross_w;
	logic               inside_q;

	// vertex i is the incoming one, vertex j the previous
	always_comb begin
		span_w = ((vtx_y <= qy) && (qy < prev_y_q)) || ((prev_y_q <= qy) && (qy < vtx_y));
		dy_w   = {prev_y_q[15], prev_y_q} - {vtx_y[15], vtx_y};
		ax_w   = {qx[15], qx} - {vtx_x[15], vtx_x};
		bx_w   = {prev_x_q[15], prev_x_q} - {vtx_x[15], vtx_x};
		by_w   = {qy[15], qy} - {vtx_y[15], vtx_y};
	end

	always_ff @(posedge clk) begin
		if (ctl.vld) begin
			prev_x_q <= vtx_x;
			prev_y_q <= vtx_y;
		end
		dy_s1   <= dy_w;
		ax_s1   <= ax_w;
		bx_s1   <= bx_w;
		by_s1   <= by_w;
		lhs_s2  <= ax_s1 * dy_s1;
		rhs_s2  <= bx_s1 * by_s1;
		dpos_s2 <= !dy_s1[16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.vld && !ctl.first && span_w;
			v_s2 <= v_s1;
		end
	end

	// span guarantees dy != 0, so the sign bit picks the direction
	assign cross_w = dpos_s2 ? (lhs_s2 < rhs_s2) : (lhs_s2 > rhs_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
		end else if (ctl.start) begin
			inside_q <= 1'b0;
		end else if (v_s2 && cross_w) begin
			inside_q <= !inside_q;
		end
	end

	assign busy    = v_s1 || v_s2;
	assign in_poly = inside_q;

endmodule

// File: sv/point_in_polygon_test.sv
// Point-in-polygon tester: vertex store, bounding box, query sequencer.
//
// Requests arrive on s_axis; tuser carries the op (clear, add vertex, test),
// tdata the coordinates. Only a test request produces a result on m_axis,
// one byte with the inside bit in bit 0.
// Clear and add-vertex are done without leaving the idle state; an add
// beyond MAX_VERTICES vertices is dropped. A test first does the bounding-box
// check; a point outside the box or a test on an empty polygon answers 0.
// Otherwise the sequencer reads the vertex store once per cycle through its
// single read port (n+1 reads for n vertices, the closing vertex first) and
// feeds the edge unit, a three-stage pipeline of span test, two 17x17
// products and compare/toggle. s_axis_tready is low from test acceptance
// until the result has been loaded into the output register. A stalled
// receiver holds the result register; a following request is still
// accepted, but the next test cannot finish until the held result is taken.
// Reset empties the polygon and resets the box; the store is not cleared.
module point_in_polygon_test import pip_pkg::*; #(
	parameter int MAX_VERTICES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [15:0] coord_x, [31:16] coord_y
	input  logic [1:0]  s_axis_tuser,   // [1:0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // [0] inside_res, [7:1] zero
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	pip_state_t state_q, state_d;

	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      last_w;
	logic signed [15:0] xmin_q, xmax_q, ymin_q, ymax_q;
	logic signed [15:0] qx_q, qy_q;
	logic [AW-1:0]      rd_ptr_q;
	logic               rd_valid_s1, rd_first_s1;
	logic               m_valid_q, m_res_q;

	logic               acc_w, box_ok_w, out_free_w;
	logic signed [15:0] in_x, in_y;
	logic               we_w, re_w, first_w, load_out_w;
	logic [AW-1:0]      raddr_w;
	logic [31:0]        rdata_w;
	pip_vtx_ctl_t       ctl_w;
	logic               busy_w, inside_w;

	assign in_x       = s_axis_tdata[15:0];
	assign in_y       = s_axis_tdata[31:16];
	assign acc_w      = s_axis_tvalid && s_axis_tready;
	assign last_w     = cnt_q - CW'(1);
	assign out_free_w = !m_valid_q || m_axis_tready;
	assign box_ok_w   = (cnt_q != '0) && (xmin_q <= qx_q) && (qx_q <= xmax_q)
	                    && (ymin_q <= qy_q) && (qy_q <= ymax_q);
	assign we_w       = acc_w && (s_axis_tuser == OP_ADD)
	                    && (cnt_q < CW'(MAX_VERTICES));

	pip_ram #(
		.WIDTH(32),
		.DEPTH(MAX_VERTICES)
	) u_store (
		.clk  (clk),
		.we   (we_w),
		.waddr(cnt_q[AW-1:0]),
		.wdata(s_axis_tdata),
		.re   (re_w),
		.raddr(raddr_w),
		.rdata(rdata_w)
	);

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		re_w          = 1'b0;
		first_w       = 1'b0;
		raddr_w       = rd_ptr_q;
		load_out_w    = 1'b0;
		ctl_w.start   = 1'b0;
		ctl_w.vld     = rd_valid_s1;
		ctl_w.first   = rd_first_s1;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && s_axis_tuser == OP_TEST) begin
					state_d = ST_BOX;
				end
			end
			ST_BOX: begin
				ctl_w.start = 1'b1;
				if (box_ok_w) begin
					re_w    = 1'b1;
					first_w = 1'b1;
					raddr_w = last_w[AW-1:0];
					state_d = ST_READ;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_READ: begin
				re_w = 1'b1;
				if (rd_ptr_q == last_w[AW-1:0]) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_valid_s1 && !busy_w) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free_w) begin
					load_out_w = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// polygon bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			xmin_q <= COORD_MAX;
			xmax_q <= COORD_MIN;
			ymin_q <= COORD_MAX;
			ymax_q <= COORD_MIN;
		end else if (acc_w && s_axis_tuser == OP_CLEAR) begin
			cnt_q  <= '0;
			xmin_q <= COORD_MAX;
			xmax_q <= COORD_MIN;
			ymin_q <= COORD_MAX;
			ymax_q <= COORD_MIN;
		end else if (we_w) begin
			cnt_q <= cnt_q + CW'(1);
			if (in_x < xmin_q) xmin_q <= in_x;
			if (in_x > xmax_q) xmax_q <= in_x;
			if (in_y < ymin_q) ymin_q <= in_y;
			if (in_y > ymax_q) ymax_q <= in_y;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_w) begin
			qx_q <= in_x;
			qy_q <= in_y;
		end
		if (load_out_w) begin
			m_res_q <= inside_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			rd_valid_s1 <= 1'b0;
			rd_first_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= re_w;
			rd_first_s1 <= first_w;
			if (state_q == ST_BOX) begin
				rd_ptr_q <= '0;
			end else if (state_q == ST_READ) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out_w) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	pip_edge u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_w),
		.vtx_x  (rdata_w[15:0]),
		.vtx_y  (rdata_w[31:16]),
		.qx     (qx_q),
		.qy     (qy_q),
		.busy   (busy_w),
		.in_poly(inside_w)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'b0, m_res_q};

endmodule
